### sv/softmax_winner_select_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the softmax winner select unit
// ---------------------------------------------------------------------------
`ifndef SOFTMAX_WINNER_SELECT_UNIT_DEFINES_SVH
`define SOFTMAX_WINNER_SELECT_UNIT_DEFINES_SVH

// implication checked every edge outside reset
`define SWS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sws_pkg.sv
// ---------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the softmax winner select unit.
// ---------------------------------------------------------------------------
package sws_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = 5;
  localparam int CNT_W = 6;
  localparam int TERM_W = 31;   // unsigned Q1.30, at most 2^30
  localparam int SUM_W = 36;
  localparam int EXP_BITS = 21;
  localparam logic [1:0] REG_MODULE_LIMIT = 2'd0;

  // queue entry from the front part to the back part
  typedef struct packed {
    logic signed [31:0] salience;
    logic               call_ok;
    logic               keep;        // loaded into the store
    logic               last_module;
  } load_beat_t;

  // exp(-2^(b-16)) in Q1.30
  function automatic logic [29:0] exp_bit(input logic [4:0] b);
    logic [29:0] t;
    unique case (b)
      5'd0:  t = 30'd1073725440;
      5'd1:  t = 30'd1073709056;
      5'd2:  t = 30'd1073676290;
      5'd3:  t = 30'd1073610760;
      5'd4:  t = 30'd1073479712;
      5'd5:  t = 30'd1073217664;
      5'd6:  t = 30'd1072693760;
      5'd7:  t = 30'd1071646719;
      5'd8:  t = 30'd1069555701;
      5'd9:  t = 30'd1065385899;
      5'd10: t = 30'd1057095000;
      5'd11: t = 30'd1040706261;
      5'd12: t = 30'd1008687096;
      5'd13: t = 30'd947573834;
      5'd14: t = 30'd836230973;
      5'd15: t = 30'd651257337;
      5'd16: t = 30'd395007542;
      5'd17: t = 30'd145315154;
      5'd18: t = 30'd19666268;
      5'd19: t = 30'd360200;
      5'd20: t = 30'd121;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

### sv/sws_ram.sv
// ---------------------------------------------------------------------------
// sws_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sws_front.sv
// ---------------------------------------------------------------------------
// sws_front
// Accepts score beats, applies the module limit, and pushes them into a
// two-entry queue toward the back part.
// ---------------------------------------------------------------------------
module sws_front
  import sws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] salience,
  input  logic               call_ok,
  input  logic               last_module,
  input  logic [CNT_W-1:0]   limit,
  output logic               q_valid,
  input  logic               q_ready,
  output load_beat_t         q_data
);

  load_beat_t  slot [2];
  logic        wp, rp;
  logic [1:0]  fill;
  logic [CNT_W-1:0] taken;
  logic        push, pop;
  load_beat_t  beat;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rp];
  assign pop      = q_valid && q_ready;

  // classify: keep only while below the limit
  always_comb begin
    beat.salience    = salience;
    beat.call_ok     = call_ok;
    beat.last_module = last_module;
    beat.keep        = (taken < limit);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= beat;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      fill  <= 2'd0;
      taken <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
        if (last_module) begin
          taken <= '0;
        end else if (beat.keep) begin
          taken <= taken + 1'b1;
        end
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### sv/sws_back.sv
// ---------------------------------------------------------------------------
// sws_back
// Stores scores and tracks the best; at step end emits a failure beat, or
// runs the exp pass, the sum and a serial divide per module for weights.
// ---------------------------------------------------------------------------
module sws_back
  import sws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  load_beat_t         q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   module_index,
  output logic [15:0]        weight,
  output logic               is_winner,
  output logic [IDX_W-1:0]   winner_index,
  output logic               step_ok,
  output logic [31:0]        step_total,
  output logic               last
);

`include "softmax_winner_select_unit_defines.svh"

  typedef enum logic [3:0] {
    LOAD, FAIL, RD, EXPB, MUL, TSTORE, DRD, DIV, EMIT
  } state_t;

  state_t state;
  logic [CNT_W-1:0]   loaded, ok_cnt;
  logic signed [31:0] lead_score;
  logic [IDX_W-1:0]   best_index;
  logic [31:0]        step_counter;
  logic [IDX_W-1:0]   ptr;
  logic [4:0]         bitn;
  logic [32:0]        diff;
  logic [TERM_W-1:0]  p;
  logic [60:0]        prod;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W+16:0]  rem;
  logic [16:0]        quo;
  logic [5:0]         dcnt;

  // score RAM: salience plus valid mark
  logic        s_we;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  logic [32:0] s_wdata, s_rdata;
  // term RAM
  logic        t_we;
  logic [TERM_W-1:0] t_rdata;

  assign s_we    = (state == LOAD) && q_valid && q_ready && q_data.keep;
  assign s_waddr = loaded[IDX_W-1:0];
  assign s_wdata = {q_data.call_ok, q_data.salience};
  assign s_raddr = ptr;
  assign t_we    = (state == TSTORE);

  // term times table entry for the current bit
  assign prod = {30'd0, p} * {31'd0, exp_bit(bitn)};

  sws_ram #(.WIDTH(33), .DEPTH(SLOTS)) u_score (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  sws_ram #(.WIDTH(TERM_W), .DEPTH(SLOTS)) u_term (
    .clk(clk), .we(t_we), .waddr(ptr), .wdata(p),
    .raddr(ptr), .rdata(t_rdata)
  );

  assign q_ready = (state == LOAD) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      loaded       <= '0;
      ok_cnt       <= '0;
      lead_score   <= '0;
      best_index   <= '0;
      step_counter <= '0;
      out_valid    <= 1'b0;
      ptr          <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // gather beats
        LOAD: begin
          if (q_valid && q_ready) begin
            if (q_data.keep && q_data.call_ok &&
                (ok_cnt == 0 || q_data.salience > lead_score)) begin
              lead_score <= q_data.salience;
              best_index <= loaded[IDX_W-1:0];
            end
            if (q_data.keep) begin
              loaded <= loaded + 1'b1;
              ok_cnt <= ok_cnt + {5'd0, q_data.call_ok};
            end
            if (q_data.last_module) begin
              ptr   <= '0;
              sum   <= '0;
              if (ok_cnt == 0 && !(q_data.keep && q_data.call_ok)) begin
                state <= FAIL;
              end else begin
                step_counter <= step_counter + 1'b1;
                state        <= RD;
              end
            end
          end
        end
        FAIL: begin
          module_index <= '0;
          weight       <= '0;
          is_winner    <= 1'b0;
          winner_index <= '0;
          step_ok      <= 1'b0;
          step_total   <= step_counter;
          last         <= 1'b1;
          out_valid    <= 1'b1;
          loaded       <= '0;
          ok_cnt       <= '0;
          lead_score   <= '0;
          best_index   <= '0;
          state        <= LOAD;
        end
        // pass one: read score
        RD: begin
          state <= EXPB;
        end
        EXPB: begin
          diff <= {lead_score[31], lead_score} - {s_rdata[31], s_rdata[31:0]};
          p    <= TERM_W'(31'd1 << 30);
          bitn <= '0;
          state <= MUL;
        end
        // one table bit per cycle
        MUL: begin
          if (!s_rdata[32] || (diff[32:21] != '0)) begin
            p     <= '0;
            state <= TSTORE;
          end else begin
            if (diff[bitn]) begin
              p <= TERM_W'((prod + 61'(1) * (61'd1 << 29)) >> 30);
            end
            if (bitn == 5'(EXP_BITS - 1)) begin
              state <= TSTORE;
            end
            bitn <= bitn + 1'b1;
          end
        end
        TSTORE: begin
          sum <= sum + SUM_W'(p);
          if ({1'b0, ptr} + 1'b1 == loaded) begin
            ptr   <= '0;
            state <= DRD;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= RD;
          end
        end
        // pass two: read term, divide
        DRD: begin
          if (!out_valid || out_ready) begin
            state <= DIV;
            dcnt  <= '0;
            rem   <= '0;
            quo   <= '0;
          end
        end
        DIV: begin
          if (dcnt == 6'd0) begin
            rem  <= {6'd0, t_rdata, 16'd0} + (SUM_W+17)'(sum >> 1);
            dcnt <= 6'd1;
          end else begin
            // restoring division, one quotient bit per cycle (17 bits)
            if (rem >= ((SUM_W+17)'(sum) << (17 - dcnt))) begin
              rem <= rem - ((SUM_W+17)'(sum) << (17 - dcnt));
              quo <= quo | (17'd1 << (17 - dcnt));
            end
            if (dcnt == 6'd17) begin
              state <= EMIT;
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        EMIT: begin
          module_index <= ptr;
          weight       <= quo[16] ? 16'hFFFF : quo[15:0];
          is_winner    <= (ptr == best_index);
          winner_index <= best_index;
          step_ok      <= 1'b1;
          step_total   <= step_counter;
          last         <= ({1'b0, ptr} + 1'b1 == loaded);
          out_valid    <= 1'b1;
          if ({1'b0, ptr} + 1'b1 == loaded) begin
            loaded     <= '0;
            ok_cnt     <= '0;
            lead_score <= '0;
            best_index <= '0;
            state      <= LOAD;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= DRD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  `SWS_ASSERT_IMPL(a_no_load_busy, (state != LOAD), !q_ready, "loaded while busy")
  `SWS_ASSERT_IMPL(a_ok_le_loaded, 1'b1, (ok_cnt <= loaded), "ok count above loaded")
  `SWS_ASSERT_NEXT(a_hold, (out_valid && !out_ready), (out_valid && $stable(weight)),
                   "result dropped")

endmodule

### sv/softmax_winner_select_unit.sv
// Step end: a failed step goes from LOAD through the FAIL state, which registers
// its result; otherwise the exp pass runs RD, EXPB, MUL and TSTORE for each
// module (a failed or cut-off one skips the table bits) before the first result.
// Throughput: one beat per cycle while loading and no result is waiting; each
// result takes a read, a restoring divide and an emit, once the prior one is taken.
// Reset: synchronous active high; limit returns to 32, counters to 0.
// ---------------------------------------------------------------------------
// softmax_winner_select_unit
// Top level: APB config, front queue, back softmax engine.
// ---------------------------------------------------------------------------
module softmax_winner_select_unit
  import sws_pkg::*;
#(
  parameter int SLOT_LIMIT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] salience,
  input  logic               call_ok,
  input  logic               last_module,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   module_index,
  output logic [15:0]        weight,
  output logic               is_winner,
  output logic [IDX_W-1:0]   winner_index,
  output logic               step_ok,
  output logic [31:0]        step_total,
  output logic               last
);

  localparam int CAP = (SLOT_LIMIT < SLOTS) ? SLOT_LIMIT : SLOTS;

  logic [CNT_W-1:0] module_limit, limit;
  logic             q_valid, q_ready;
  load_beat_t       q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODULE_LIMIT) ? {26'd0, module_limit} : 32'd0;
  assign limit  = (module_limit < CNT_W'(CAP)) ? module_limit : CNT_W'(CAP);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      module_limit <= CNT_W'(32);
    end else if (psel && penable && pwrite && paddr == REG_MODULE_LIMIT) begin
      module_limit <= pwdata[CNT_W-1:0];
    end
  end

  sws_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .salience(salience), .call_ok(call_ok), .last_module(last_module),
    .limit(limit), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  sws_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .module_index(module_index),
    .weight(weight), .is_winner(is_winner), .winner_index(winner_index),
    .step_ok(step_ok), .step_total(step_total), .last(last)
  );

endmodule

### tb/sv/softmax_winner_select_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// softmax_winner_select_unit_tb
// Drives score beats through the unit, predicts the softmax weights and the
// winner of each step, and compares every result beat in order.
// ---------------------------------------------------------------------------
module softmax_winner_select_unit_tb;
  import sws_pkg::*;

  localparam int WDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 1600;

  // one result beat as predicted
  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] wgt;
    logic        win;
    logic [4:0]  widx;
    logic        ok;
    logic [31:0] total;
    logic        lst;
  } weight_beat_t;

  // directed row; chk means the typed expectation is compared too
  typedef struct packed {
    logic [31:0] sal;
    logic        ok;
    logic        lm;
    logic        chk;
    logic [15:0] wgt;
    logic        win;
  } score_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic signed [31:0] salience = '0;
  logic call_ok = 1'b0, last_module = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [4:0] module_index, winner_index;
  logic [15:0] weight;
  logic is_winner, step_ok, last;
  logic [31:0] step_total;

  softmax_winner_select_unit dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [31:0] p_score [SLOTS];
  logic               p_valid [SLOTS];
  int unsigned        p_loaded, p_succ, p_best_idx;
  logic signed [31:0] p_best;
  logic [31:0]        p_steps;
  logic [5:0]         p_limit;

  weight_beat_t weight_q[$];
  int  errors = 0;
  int  send_idle = 35, recv_idle = 76;
  bit  recv_hold = 0;
  int  idle_cnt = 0;

  function automatic logic [63:0] exp_term_q30(logic signed [31:0] s);
    logic [63:0] d, p, t;
    d = 64'($signed(p_best)) - 64'(s);
    p = 64'd1 << 30;
    if (d >> 21) return 0;
    for (int b = 0; b < EXP_BITS; b++)
      if (d[b]) begin
        t = 64'(exp_bit(5'(b)));
        p = (p * t + (64'd1 << 29)) >> 30;
      end
    return p;
  endfunction

  task automatic predict_softmax(logic signed [31:0] s, logic ok, logic lm);
    int unsigned lim;
    logic [63:0] terms [SLOTS];
    logic [63:0] sum, w;
    weight_beat_t r;
    lim = (p_limit < SLOTS) ? p_limit : SLOTS;
    if (p_loaded < lim) begin
      p_score[p_loaded] = s;
      p_valid[p_loaded] = ok;
      if (ok) begin
        if (p_succ == 0 || s > p_best) begin
          p_best = s;
          p_best_idx = p_loaded;
        end
        p_succ++;
      end
      p_loaded++;
    end
    if (!lm) return;
    if (p_succ == 0) begin
      r = '{idx: 0, wgt: 0, win: 0, widx: 0, ok: 0, total: p_steps, lst: 1};
      weight_q.push_back(r);
    end else begin
      sum = 0;
      for (int i = 0; i < p_loaded; i++) begin
        terms[i] = p_valid[i] ? exp_term_q30(p_score[i]) : 0;
        sum += terms[i];
      end
      p_steps++;
      for (int i = 0; i < p_loaded; i++) begin
        w = (terms[i] * 65536 + sum / 2) / sum;
        if (w > 65535) w = 65535;
        r = '{idx: 5'(i), wgt: 16'(w), win: (i == p_best_idx), widx: 5'(p_best_idx),
              ok: 1, total: p_steps, lst: (i + 1 == p_loaded)};
        weight_q.push_back(r);
      end
    end
    p_loaded = 0; p_succ = 0; p_best = 0; p_best_idx = 0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $time);
    errors++;
  endtask

  // APB write, setup then access
  task automatic write_limit(logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_MODULE_LIMIT; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    p_limit = v[5:0];
  endtask

  // send one score beat and predict it at acceptance; valid stays up
  // between back-to-back beats and drops only while the sender idles
  task automatic send_score(logic [31:0] s, logic ok, logic lm);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1; salience <= s; call_ok <= ok; last_module <= lm;
    do @(posedge clk); while (!in_ready);
    predict_softmax(s, ok, lm);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (weight_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (recv_hold) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker
  always @(posedge clk) begin
    weight_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (weight_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(module_index), 0);
      end else begin
        e = weight_q.pop_front();
        if (module_index !== e.idx)
          report_mismatch("module_index", 32'(module_index), 32'(e.idx));
        if (weight !== e.wgt) report_mismatch("weight", 32'(weight), 32'(e.wgt));
        if (is_winner !== e.win)
          report_mismatch("is_winner", 32'(is_winner), 32'(e.win));
        if (winner_index !== e.widx)
          report_mismatch("winner_index", 32'(winner_index), 32'(e.widx));
        if (step_ok !== e.ok) report_mismatch("step_ok", 32'(step_ok), 32'(e.ok));
        if (step_total !== e.total) report_mismatch("step_total", step_total, e.total);
        if (last !== e.lst) report_mismatch("last", 32'(last), 32'(e.lst));
      end
    end
  end

  // watchdog on cycles with no beat accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // directed rows: typed weight checked only where obvious
  score_row_t dir_rows[] = '{
    '{32'h0000_0000, 0, 1, 0, 0, 0},            // no success at all
    '{32'h7FFF_FFFF, 1, 1, 1, 16'd65535, 1},    // single module, max score
    '{32'h8000_0000, 1, 1, 1, 16'd65535, 1},    // single module, min score
    '{32'h8000_0000, 1, 0, 0, 0, 0},            // extremes: far apart
    '{32'h7FFF_FFFF, 1, 1, 0, 0, 0},
    '{32'h0001_0000, 0, 0, 0, 0, 0},            // failed module gets zero
    '{32'h0001_0000, 1, 0, 0, 0, 0},
    '{32'h0001_0000, 1, 0, 0, 0, 0},            // tie: first wins
    '{32'h0000_8000, 1, 1, 0, 0, 0},
    '{32'h0000_0001, 1, 0, 0, 0, 0},            // one-lsb apart
    '{32'h0000_0000, 1, 0, 0, 0, 0},
    '{32'h001F_FFFF, 1, 0, 0, 0, 0},            // just inside cut-off
    '{32'h0020_0000, 1, 0, 0, 0, 0},            // at the cut-off
    '{32'hFFFF_FFFF, 1, 1, 0, 0, 0}
  };

  task automatic random_step(int n, bit good);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      logic [31:0] s;
      case ($urandom_range(3))
        0: s = $urandom;
        1: s = base + $urandom_range(32'h0040_0000);
        2: s = base - $urandom_range(32'h0004_0000);
        default: s = base ^ (32'd1 << $urandom_range(31));
      endcase
      send_score(s, good ? ($urandom_range(9) != 0) : 1'($urandom_range(1)), i == n - 1);
    end
  endtask

  initial begin
    p_loaded = 0; p_succ = 0; p_best = 0; p_best_idx = 0; p_steps = 0; p_limit = 32;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    foreach (dir_rows[k]) begin
      send_score(dir_rows[k].sal, dir_rows[k].ok, dir_rows[k].lm);
      if (dir_rows[k].chk) begin
        if (weight_q.size() == 0) report_mismatch("directed row lacks result", k, 0);
        else if (weight_q[$].wgt !== dir_rows[k].wgt || weight_q[$].win !== dir_rows[k].win)
          report_mismatch("directed typed result", 32'(weight_q[$].wgt),
                          32'(dir_rows[k].wgt));
      end
    end
    wait_drained();

    // limit extremes: one, zero, above range
    write_limit(1);
    send_score(32'h0000_1000, 0, 0);
    send_score(32'h0000_2000, 1, 1);
    wait_drained();
    write_limit(0);
    send_score(32'h0000_1000, 1, 1);
    wait_drained();
    write_limit(63);
    random_step(33, 1);
    wait_drained();
    write_limit(5);
    random_step(8, 1);
    wait_drained();
    write_limit(32);

    // phase one: sender idles lightly, receiver heavily; long hold-off
    fork
      begin
        recv_hold = 1;
        repeat (2000) @(posedge clk);
        recv_hold = 0;
      end
      repeat (5) random_step($urandom_range(1, 6), 1);
    join
    random_step(2, 0);
    wait_drained();

    // phase two: swapped
    send_idle = 76; recv_idle = 35;
    repeat (5) random_step($urandom_range(1, 5), $urandom_range(3) != 0);
    wait_drained();

    // phase three: no idling
    send_idle = 0; recv_idle = 0;
    repeat (4) random_step($urandom_range(1, 5), $urandom_range(3) != 0);
    random_step(12, 1);
    wait_drained();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
